// File: hdl/dmc_pkg.sv
package dmc_pkg;

  localparam int HORIZON = 16;
  localparam int HISTORY = 32;

  localparam int DATA_W = 32;
  localparam int FRAC_W = 16;
  localparam int REQ_W  = 2;
  localparam int ROW_W  = 4;
  localparam int COL_W  = 5;
  localparam int CFG_AW = 2;

  localparam int GAIN_AW   = (HORIZON > 1) ? $clog2(HORIZON) : 1;
  localparam int HIST_AW   = (HISTORY > 1) ? $clog2(HISTORY) : 1;
  localparam int FILL_W    = $clog2(HISTORY + 1);
  localparam int MAT_DEPTH = HORIZON * HISTORY;
  localparam int MAT_AW    = (MAT_DEPTH > 1) ? $clog2(MAT_DEPTH) : 1;

  localparam int PROD_W = 2 * DATA_W;
  // floored products are 48 bits; headroom for a full row plus the measurement
  localparam int ACC_W  = PROD_W - FRAC_W + $clog2(HISTORY + HORIZON + 1);

  localparam int IN_FIELDS_W = ROW_W + COL_W + 3 * DATA_W;
  localparam int IN_DATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_DATA_W  = 2 * DATA_W;

  // tdata field offsets on the input side
  localparam int ROW_LSB  = 0;
  localparam int COL_LSB  = ROW_LSB + ROW_W;
  localparam int COEF_LSB = COL_LSB + COL_W;
  localparam int MEAS_LSB = COEF_LSB + DATA_W;
  localparam int SETP_LSB = MEAS_LSB + DATA_W;

  localparam logic signed [DATA_W-1:0] STEP_MIN_RST  = -32'sd65536;
  localparam logic signed [DATA_W-1:0] STEP_MAX_RST  = 32'sd65536;
  localparam logic signed [DATA_W-1:0] DRIVE_MIN_RST = -32'sd655360;
  localparam logic signed [DATA_W-1:0] DRIVE_MAX_RST = 32'sd655360;

  typedef logic signed [DATA_W-1:0] q_t;
  typedef logic signed [ACC_W-1:0]  acc_t;

  typedef enum logic [REQ_W-1:0] {
    REQ_LOAD_MAT  = 2'd0,
    REQ_LOAD_GAIN = 2'd1,
    REQ_SAMPLE    = 2'd2
  } req_t;

  typedef enum logic [CFG_AW-1:0] {
    CFG_STEP_MIN  = 2'd0,
    CFG_STEP_MAX  = 2'd1,
    CFG_DRIVE_MIN = 2'd2,
    CFG_DRIVE_MAX = 2'd3
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ROW,
    ST_DRAIN,
    ST_ERR,
    ST_GMUL,
    ST_GACC,
    ST_CLAMP,
    ST_DRIVE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic mul_v;
    logic to_outer;
    logic inner_load;
    logic outer_clr;
  } mac_ctrl_t;

  function automatic q_t sat32(input acc_t v);
    logic [ACC_W-DATA_W:0] hi;
    q_t r;
    hi = v[ACC_W-1:DATA_W-1];
    if ((&hi) || !(|hi)) r = v[DATA_W-1:0];
    else if (v[ACC_W-1]) r = {1'b1, {(DATA_W-1){1'b0}}};
    else r = {1'b0, {(DATA_W-1){1'b1}}};
    return r;
  endfunction

  // lower test first: with crossed limits, a value below lo gives lo and any other gives hi
  function automatic q_t clamp(input q_t v, input q_t lo, input q_t hi);
    q_t r;
    if (v < lo) r = lo;
    else if (v > hi) r = hi;
    else r = v;
    return r;
  endfunction

endpackage

// File: hdl/dmc_coef.sv
module dmc_coef (
  input  logic                       clk,
  input  logic                       mat_we,
  input  logic                       gain_we,
  input  logic [dmc_pkg::ROW_W-1:0]  wr_row,
  input  logic [dmc_pkg::COL_W-1:0]  wr_col,
  input  dmc_pkg::q_t                wr_data,
  input  logic [dmc_pkg::GAIN_AW-1:0] rd_row,
  input  logic [dmc_pkg::HIST_AW-1:0] rd_col,
  output dmc_pkg::q_t                mat_q,
  output dmc_pkg::q_t                gain_q
);

  dmc_pkg::q_t mat_mem [dmc_pkg::MAT_DEPTH];
  dmc_pkg::q_t gain_mem [dmc_pkg::HORIZON];

  logic [dmc_pkg::MAT_AW-1:0]  mat_wa;
  logic [dmc_pkg::MAT_AW-1:0]  mat_ra;
  logic [dmc_pkg::GAIN_AW-1:0] gain_wa;
  logic                        row_ok;
  logic                        col_ok;

  assign row_ok  = int'(wr_row) < dmc_pkg::HORIZON;
  assign col_ok  = int'(wr_col) < dmc_pkg::HISTORY;
  assign mat_wa  = dmc_pkg::MAT_AW'(int'(wr_row) * dmc_pkg::HISTORY + int'(wr_col));
  assign mat_ra  = dmc_pkg::MAT_AW'(int'(rd_row) * dmc_pkg::HISTORY + int'(rd_col));
  assign gain_wa = dmc_pkg::GAIN_AW'(wr_row);

  always_ff @(posedge clk) begin
    if (mat_we && row_ok && col_ok) begin
      mat_mem[mat_wa] <= wr_data;
    end
    mat_q <= mat_mem[mat_ra];
  end

  always_ff @(posedge clk) begin
    if (gain_we && row_ok) begin
      gain_mem[gain_wa] <= wr_data;
    end
    gain_q <= gain_mem[rd_row];
  end

endmodule

// File: hdl/dmc_hist.sv
module dmc_hist (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push,
  input  dmc_pkg::q_t                 push_data,
  input  logic [dmc_pkg::HIST_AW-1:0] rd_col,
  output dmc_pkg::q_t                 rd_q,
  output logic                        rd_ok
);

  // circular buffer: head_r holds the newest increment (column 0);
  // columns at or beyond the fill count read as zero via rd_ok
  dmc_pkg::q_t hist_mem [dmc_pkg::HISTORY];

  logic [dmc_pkg::HIST_AW-1:0] head_r, head_nxt;
  logic [dmc_pkg::FILL_W-1:0]  fill_r, fill_nxt;
  logic [dmc_pkg::HIST_AW-1:0] rd_addr;

  always_comb begin
    if (int'(head_r) >= int'(rd_col)) begin
      rd_addr = dmc_pkg::HIST_AW'(int'(head_r) - int'(rd_col));
    end else begin
      rd_addr = dmc_pkg::HIST_AW'(int'(head_r) + dmc_pkg::HISTORY - int'(rd_col));
    end
  end

  always_comb begin
    head_nxt = head_r;
    fill_nxt = fill_r;
    if (push) begin
      if (head_r == dmc_pkg::HIST_AW'(dmc_pkg::HISTORY - 1)) head_nxt = '0;
      else head_nxt = head_r + 1'b1;
      if (int'(fill_r) < dmc_pkg::HISTORY) fill_nxt = fill_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      fill_r <= '0;
    end else begin
      head_r <= head_nxt;
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      hist_mem[head_nxt] <= push_data;
    end
    rd_q  <= hist_mem[rd_addr];
    rd_ok <= dmc_pkg::FILL_W'(rd_col) < fill_r;
  end

endmodule

// File: hdl/dmc_mac.sv
module dmc_mac (
  input  logic               clk,
  input  logic               rst_n,
  input  dmc_pkg::mac_ctrl_t ctrl,
  input  dmc_pkg::q_t        mul_a,
  input  dmc_pkg::q_t        mul_b,
  input  dmc_pkg::q_t        init_val,
  output dmc_pkg::acc_t      inner_acc,
  output dmc_pkg::acc_t      outer_acc,
  output logic               busy
);

  logic signed [dmc_pkg::PROD_W-1:0] prod_r;
  logic                              prod_v_r;
  logic                              outer_tag_r;
  dmc_pkg::acc_t                     prod_sh;
  dmc_pkg::acc_t                     inner_r;
  dmc_pkg::acc_t                     outer_r;

  // arithmetic shift floors the Q32.32 product to Q16.16
  assign prod_sh = dmc_pkg::ACC_W'(prod_r >>> dmc_pkg::FRAC_W);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_v_r    <= 1'b0;
      outer_tag_r <= 1'b0;
    end else begin
      prod_v_r    <= ctrl.mul_v;
      outer_tag_r <= ctrl.to_outer;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= dmc_pkg::PROD_W'(mul_a) * dmc_pkg::PROD_W'(mul_b);
  end

  always_ff @(posedge clk) begin
    if (ctrl.inner_load) begin
      inner_r <= dmc_pkg::ACC_W'(init_val);
    end else if (prod_v_r && !outer_tag_r) begin
      inner_r <= inner_r + prod_sh;
    end
    if (ctrl.outer_clr) begin
      outer_r <= '0;
    end else if (prod_v_r && outer_tag_r) begin
      outer_r <= outer_r + prod_sh;
    end
  end

  assign inner_acc = inner_r;
  assign outer_acc = outer_r;
  assign busy      = prod_v_r;

endmodule

// File: hdl/dmc_control_step_core.sv
// Loads are accepted only while idle and written into the coefficient memories.
// A sample walks HORIZON rows of HISTORY memory reads through one shared
// multiply-accumulate; the next item is taken only once the result sits in the
// output register, which waits while an earlier result is still unaccepted.
// rst_n (synchronous, active low) restores the limit registers, empties the
// increment history and zeroes the last control; coefficient memories keep contents.
module dmc_control_step_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // row_index, col_index, coef_value, measured, setpoint (lowest first), zero pad
  input  logic [dmc_pkg::IN_DATA_W-1:0]   in_tdata,
  // req_type
  input  logic [dmc_pkg::REQ_W-1:0]       in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // drive, drive_step (lowest first)
  output logic [dmc_pkg::OUT_DATA_W-1:0]  out_tdata,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [dmc_pkg::CFG_AW-1:0]      cfg_addr,
  input  logic [dmc_pkg::DATA_W-1:0]      cfg_data
);

  dmc_pkg::state_t state_r, state_nxt;
  logic [dmc_pkg::GAIN_AW-1:0] row_r, row_nxt;
  logic [dmc_pkg::HIST_AW-1:0] col_r, col_nxt;
  logic                        rd_v_r;
  logic                        in_fire;
  logic                        done_fire;
  logic                        drain_done;
  dmc_pkg::req_t               req;
  dmc_pkg::mac_ctrl_t          mac_ctrl;
  dmc_pkg::q_t                 mul_a, mul_b;

  dmc_pkg::q_t step_min_r, step_max_r, drive_min_r, drive_max_r;
  dmc_pkg::q_t meas_r, setp_r, y0_r, err_r, dv_r, drive_r, last_drive_r;
  dmc_pkg::q_t out_drive_r, out_step_r;
  logic        out_valid_r;

  dmc_pkg::q_t   mat_q, gain_q, hist_q;
  logic          hist_ok;
  dmc_pkg::acc_t inner_acc, outer_acc;
  logic          mac_busy;

  assign req       = dmc_pkg::req_t'(in_tuser);
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = rst_n;

  dmc_coef u_coef (
    .clk     (clk),
    .mat_we  (in_fire && req == dmc_pkg::REQ_LOAD_MAT),
    .gain_we (in_fire && req == dmc_pkg::REQ_LOAD_GAIN),
    .wr_row  (in_tdata[dmc_pkg::ROW_LSB +: dmc_pkg::ROW_W]),
    .wr_col  (in_tdata[dmc_pkg::COL_LSB +: dmc_pkg::COL_W]),
    .wr_data (in_tdata[dmc_pkg::COEF_LSB +: dmc_pkg::DATA_W]),
    .rd_row  (row_r),
    .rd_col  (col_r),
    .mat_q   (mat_q),
    .gain_q  (gain_q)
  );

  dmc_hist u_hist (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (done_fire),
    .push_data (dv_r),
    .rd_col    (col_r),
    .rd_q      (hist_q),
    .rd_ok     (hist_ok)
  );

  dmc_mac u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (mac_ctrl),
    .mul_a     (mul_a),
    .mul_b     (mul_b),
    .init_val  (meas_r),
    .inner_acc (inner_acc),
    .outer_acc (outer_acc),
    .busy      (mac_busy)
  );

  assign drain_done = !rd_v_r && !mac_busy;

  always_comb begin
    if (state_r == dmc_pkg::ST_GMUL) begin
      mul_a = gain_q;
      mul_b = err_r;
    end else begin
      mul_a = mat_q;
      mul_b = hist_ok ? hist_q : '0;
    end
  end

  always_comb begin
    state_nxt           = state_r;
    row_nxt             = row_r;
    col_nxt             = col_r;
    in_tready           = 1'b0;
    done_fire           = 1'b0;
    mac_ctrl.mul_v      = rd_v_r;
    mac_ctrl.to_outer   = 1'b0;
    mac_ctrl.inner_load = 1'b0;
    mac_ctrl.outer_clr  = 1'b0;
    unique case (state_r)
      dmc_pkg::ST_IDLE: begin
        in_tready = rst_n;
        if (in_tvalid && req == dmc_pkg::REQ_SAMPLE) begin
          mac_ctrl.outer_clr = 1'b1;
          row_nxt            = '0;
          col_nxt            = '0;
          state_nxt          = dmc_pkg::ST_ROW;
        end
      end
      dmc_pkg::ST_ROW: begin
        mac_ctrl.inner_load = (col_r == '0);
        if (col_r == dmc_pkg::HIST_AW'(dmc_pkg::HISTORY - 1)) begin
          state_nxt = dmc_pkg::ST_DRAIN;
        end else begin
          col_nxt = col_r + 1'b1;
        end
      end
      dmc_pkg::ST_DRAIN: begin
        if (drain_done) state_nxt = dmc_pkg::ST_ERR;
      end
      dmc_pkg::ST_ERR: begin
        state_nxt = dmc_pkg::ST_GMUL;
      end
      dmc_pkg::ST_GMUL: begin
        mac_ctrl.mul_v    = 1'b1;
        mac_ctrl.to_outer = 1'b1;
        state_nxt         = dmc_pkg::ST_GACC;
      end
      dmc_pkg::ST_GACC: begin
        if (row_r == dmc_pkg::GAIN_AW'(dmc_pkg::HORIZON - 1)) begin
          state_nxt = dmc_pkg::ST_CLAMP;
        end else begin
          row_nxt   = row_r + 1'b1;
          col_nxt   = '0;
          state_nxt = dmc_pkg::ST_ROW;
        end
      end
      dmc_pkg::ST_CLAMP: begin
        state_nxt = dmc_pkg::ST_DRIVE;
      end
      dmc_pkg::ST_DRIVE: begin
        state_nxt = dmc_pkg::ST_DONE;
      end
      dmc_pkg::ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          done_fire = 1'b1;
          state_nxt = dmc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = dmc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= dmc_pkg::ST_IDLE;
      row_r        <= '0;
      col_r        <= '0;
      rd_v_r       <= 1'b0;
      out_valid_r  <= 1'b0;
      last_drive_r <= '0;
    end else begin
      state_r <= state_nxt;
      row_r   <= row_nxt;
      col_r   <= col_nxt;
      rd_v_r  <= (state_r == dmc_pkg::ST_ROW);
      if (done_fire) begin
        out_valid_r  <= 1'b1;
        last_drive_r <= drive_r;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_min_r  <= dmc_pkg::STEP_MIN_RST;
      step_max_r  <= dmc_pkg::STEP_MAX_RST;
      drive_min_r <= dmc_pkg::DRIVE_MIN_RST;
      drive_max_r <= dmc_pkg::DRIVE_MAX_RST;
    end else if (cfg_valid) begin
      unique case (dmc_pkg::cfg_idx_t'(cfg_addr))
        dmc_pkg::CFG_STEP_MIN:  step_min_r  <= cfg_data;
        dmc_pkg::CFG_STEP_MAX:  step_max_r  <= cfg_data;
        dmc_pkg::CFG_DRIVE_MIN: drive_min_r <= cfg_data;
        dmc_pkg::CFG_DRIVE_MAX: drive_max_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // datapath words
  always_ff @(posedge clk) begin
    if (in_fire && req == dmc_pkg::REQ_SAMPLE) begin
      meas_r <= in_tdata[dmc_pkg::MEAS_LSB +: dmc_pkg::DATA_W];
      setp_r <= in_tdata[dmc_pkg::SETP_LSB +: dmc_pkg::DATA_W];
    end
    if (state_r == dmc_pkg::ST_DRAIN && drain_done) begin
      y0_r <= dmc_pkg::sat32(inner_acc);
    end
    if (state_r == dmc_pkg::ST_ERR) begin
      err_r <= dmc_pkg::sat32(dmc_pkg::ACC_W'(setp_r) - dmc_pkg::ACC_W'(y0_r));
    end
    if (state_r == dmc_pkg::ST_CLAMP) begin
      dv_r <= dmc_pkg::clamp(dmc_pkg::sat32(outer_acc), step_min_r, step_max_r);
    end
    if (state_r == dmc_pkg::ST_DRIVE) begin
      drive_r <= dmc_pkg::clamp(
        dmc_pkg::sat32(dmc_pkg::ACC_W'(last_drive_r) + dmc_pkg::ACC_W'(dv_r)),
        drive_min_r, drive_max_r);
    end
    if (done_fire) begin
      out_drive_r <= drive_r;
      out_step_r  <= dv_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_step_r, out_drive_r};

`ifndef SYNTHESIS
  a_mac_quiet_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == dmc_pkg::ST_IDLE) |-> (!mac_busy && !rd_v_r))
    else $error("multiply-accumulate active while idle");

  a_sample_starts_row0: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && req == dmc_pkg::REQ_SAMPLE) |=>
      (state_r == dmc_pkg::ST_ROW && row_r == '0 && col_r == '0))
    else $error("sample did not start at row 0 column 0");

  a_done_shows_word: assert property (@(posedge clk) disable iff (!rst_n)
    done_fire |=> (out_tvalid && out_tdata == {$past(dv_r), $past(drive_r)}))
    else $error("finished result not presented");

  a_read_valid_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    rd_v_r |-> (state_r == dmc_pkg::ST_ROW || state_r == dmc_pkg::ST_DRAIN))
    else $error("memory read returned outside the row walk");
`endif

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import dmc_pkg::*;

  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam q_t Q_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam q_t Q_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam int SETTLE_CYCLES = 700;
  localparam int HOLD_CYCLES   = 4000;
  localparam int IDLE_LIMIT    = 20000;

  typedef struct {
    logic [REQ_W-1:0] kind;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    q_t               coef;
    q_t               meas;
    q_t               setp;
  } ctrl_req_t;

  typedef struct {
    q_t drive;
    q_t drive_step;
  } ctrl_out_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [REQ_W-1:0]      in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_AW-1:0]     cfg_addr = '0;
  logic [DATA_W-1:0]     cfg_data = '0;

  dmc_control_step_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // controller state as the testbench sees it
  q_t resp_mat [MAT_DEPTH];
  q_t gain_vec [HORIZON];
  q_t inc_hist [HISTORY];
  q_t prev_drive = '0;
  q_t step_lo  = STEP_MIN_RST;
  q_t step_hi  = STEP_MAX_RST;
  q_t drive_lo = DRIVE_MIN_RST;
  q_t drive_hi = DRIVE_MAX_RST;

  ctrl_req_t pend_words [$];
  ctrl_out_t pending_outputs [$];
  int        err_count = 0;
  int        result_no = 0;

  initial begin
    for (int i = 0; i < HISTORY; i++) inc_hist[i] = '0;
  end

  // Q16.16 x Q16.16, floored back to Q16.16 (arithmetic shift floors)
  function automatic longint floor_mul(input q_t a, input q_t b);
    longint p;
    p = longint'(a) * longint'(b);
    return p >>> FRAC_W;
  endfunction

  function automatic q_t sat_q(input longint v);
    if (v < longint'(Q_MIN)) return Q_MIN;
    if (v > longint'(Q_MAX)) return Q_MAX;
    return q_t'(v);
  endfunction

  function automatic q_t limit_q(input q_t v, input q_t lo, input q_t hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  task automatic predict_control_step(input ctrl_req_t rq);
    longint free_acc;
    longint gain_acc;
    q_t     y0;
    q_t     err;
    q_t     dv;
    q_t     drv;
    ctrl_out_t res;
    case (rq.kind)
      REQ_LOAD_MAT:  resp_mat[int'(rq.row) * HISTORY + int'(rq.col)] = rq.coef;
      REQ_LOAD_GAIN: gain_vec[rq.row] = rq.coef;
      REQ_SAMPLE: begin
        gain_acc = 0;
        for (int r = 0; r < HORIZON; r++) begin
          free_acc = longint'(rq.meas);
          for (int c = 0; c < HISTORY; c++)
            free_acc += floor_mul(resp_mat[r * HISTORY + c], inc_hist[c]);
          y0 = sat_q(free_acc);
          err = sat_q(longint'(rq.setp) - longint'(y0));
          gain_acc += floor_mul(gain_vec[r], err);
        end
        dv = limit_q(sat_q(gain_acc), step_lo, step_hi);
        drv = limit_q(sat_q(longint'(prev_drive) + longint'(dv)), drive_lo, drive_hi);
        prev_drive = drv;
        for (int c = HISTORY - 1; c > 0; c--) inc_hist[c] = inc_hist[c-1];
        inc_hist[0] = dv;
        res.drive = drv;
        res.drive_step = dv;
        pending_outputs.push_back(res);
      end
      default: ;  // unused request code: dropped without effect
    endcase
  endtask

  task automatic report_mismatch(input string what, input q_t got, input q_t want);
    $display("mismatch on result %0d, %s: got %0d expected %0d", result_no, what, got, want);
    err_count++;
  endtask

  // ---------------- input driver ----------------
  ctrl_req_t cur_word;
  ctrl_req_t nxt_word;
  int        burst_left = 0;
  int        gap_left = 0;
  logic [IN_DATA_W-1:0] word_bits;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) predict_control_step(cur_word);
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (pend_words.size() != 0) begin
          nxt_word = pend_words.pop_front();
          word_bits = '0;
          word_bits[ROW_LSB  +: ROW_W]  = nxt_word.row;
          word_bits[COL_LSB  +: COL_W]  = nxt_word.col;
          word_bits[COEF_LSB +: DATA_W] = nxt_word.coef;
          word_bits[MEAS_LSB +: DATA_W] = nxt_word.meas;
          word_bits[SETP_LSB +: DATA_W] = nxt_word.setp;
          in_tdata  <= word_bits;
          in_tuser  <= nxt_word.kind;
          in_tvalid <= 1'b1;
          cur_word = nxt_word;
          if (burst_left > 0) burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------- result receiver ----------------
  logic hold_req = 1'b0;
  int   hold_cnt = 0;
  int   stretch_left = 0;
  int   stall_pct = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (hold_req) begin
        hold_req = 1'b0;
        hold_cnt = HOLD_CYCLES;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_tready <= 1'b0;
      end else begin
        if (stretch_left == 0) begin
          stretch_left = $urandom_range(1, 40);
          case ($urandom_range(0, 3))
            0: stall_pct = 0;
            1: stall_pct = 30;
            2: stall_pct = 70;
            default: stall_pct = 95;
          endcase
        end else begin
          stretch_left--;
        end
        out_tready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // ---------------- result monitor ----------------
  ctrl_out_t want_out;

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_outputs.size() == 0) begin
        report_mismatch("unexpected word", q_t'(out_tdata[DATA_W-1:0]), '0);
      end else begin
        want_out = pending_outputs.pop_front();
        if (out_tdata[DATA_W-1:0] !== want_out.drive)
          report_mismatch("drive", q_t'(out_tdata[DATA_W-1:0]), want_out.drive);
        if (out_tdata[2*DATA_W-1:DATA_W] !== want_out.drive_step)
          report_mismatch("drive_step", q_t'(out_tdata[2*DATA_W-1:DATA_W]),
                          want_out.drive_step);
      end
      result_no++;
    end
  end

  // ---------------- watchdog ----------------
  int idle_cycles = 0;

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // ---------------- stimulus ----------------
  function automatic q_t rand_small();
    int v;
    v = int'($urandom_range(0, 262144)) - 131072;
    return q_t'(v);
  endfunction

  function automatic q_t rand_coef();
    int v;
    case ($urandom_range(0, 19))
      0: return q_t'($urandom);
      1: begin
        case ($urandom_range(0, 4))
          0: return Q_MIN;
          1: return Q_MAX;
          2: return q_t'(0);
          3: return q_t'(-1);
          default: return q_t'(1);
        endcase
      end
      2, 3: begin
        v = int'($urandom_range(0, 2097152)) - 1048576;
        return q_t'(v);
      end
      default: return rand_small();
    endcase
  endfunction

  task automatic push_load(input logic [REQ_W-1:0] kind, input int row, input int col,
                           input q_t coef);
    ctrl_req_t rq;
    rq.kind = kind;
    rq.row  = ROW_W'(row);
    rq.col  = COL_W'(col);
    rq.coef = coef;
    rq.meas = q_t'($urandom);
    rq.setp = q_t'($urandom);
    pend_words.push_back(rq);
  endtask

  task automatic push_sample(input q_t meas, input q_t setp);
    ctrl_req_t rq;
    rq.kind = REQ_SAMPLE;
    rq.row  = ROW_W'($urandom_range(0, 15));
    rq.col  = COL_W'($urandom_range(0, 31));
    rq.coef = q_t'($urandom);
    rq.meas = meas;
    rq.setp = setp;
    pend_words.push_back(rq);
  endtask

  task automatic push_ignored();
    push_load(REQ_UNUSED, $urandom_range(0, 15), $urandom_range(0, 31), q_t'($urandom));
  endtask

  // ignored words do not count towards n
  task automatic add_random(input int n);
    int done;
    int pick;
    done = 0;
    while (done < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        push_sample(rand_coef(), rand_coef());
        done++;
      end else if (pick < 56) begin
        push_ignored();
      end else if (pick < 86) begin
        push_load(REQ_LOAD_MAT, $urandom_range(0, 15), $urandom_range(0, 31), rand_coef());
        done++;
      end else begin
        push_load(REQ_LOAD_GAIN, $urandom_range(0, 15), 0, rand_coef());
        done++;
      end
    end
  endtask

  // nothing queued, nothing in flight, then room for a trailing load to finish
  task automatic wait_idle();
    while (pend_words.size() != 0 || in_tvalid || pending_outputs.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input q_t val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_addr  <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_STEP_MIN:  step_lo  = val;
      CFG_STEP_MAX:  step_hi  = val;
      CFG_DRIVE_MIN: drive_lo = val;
      CFG_DRIVE_MAX: drive_hi = val;
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  task automatic write_limits(input q_t smin, input q_t smax, input q_t dmin, input q_t dmax);
    write_reg(CFG_STEP_MIN, smin);
    write_reg(CFG_STEP_MAX, smax);
    write_reg(CFG_DRIVE_MIN, dmin);
    write_reg(CFG_DRIVE_MAX, dmax);
  endtask

  initial begin
    rst_n = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // whole matrix and gain row first: no sample may read an unwritten entry
    for (int r = 0; r < HORIZON; r++)
      for (int c = 0; c < HISTORY; c++)
        push_load(REQ_LOAD_MAT, r, c, rand_small());
    for (int r = 0; r < HORIZON; r++)
      push_load(REQ_LOAD_GAIN, r, 0, rand_small());

    // directed, reset limits
    push_sample(q_t'(0), q_t'(0));
    push_sample(q_t'(65536), q_t'(131072));
    push_ignored();
    push_sample(Q_MAX, Q_MIN);
    push_sample(Q_MIN, Q_MAX);
    push_sample(q_t'(-1), q_t'(1));
    push_load(REQ_LOAD_GAIN, 0, 0, Q_MAX);
    push_load(REQ_LOAD_MAT, 15, 31, Q_MIN);
    push_load(REQ_LOAD_MAT, 0, 0, q_t'(-1));
    push_sample(Q_MAX, Q_MAX);
    push_sample(q_t'(0), q_t'(655360));
    push_sample(q_t'(-655360), q_t'(0));
    push_load(REQ_LOAD_GAIN, 15, 0, Q_MIN);
    push_ignored();
    push_sample(q_t'(1000), q_t'(-1000));
    push_load(REQ_LOAD_GAIN, 0, 0, rand_small());
    push_load(REQ_LOAD_GAIN, 15, 0, rand_small());
    push_load(REQ_LOAD_MAT, 15, 31, rand_small());
    push_load(REQ_LOAD_MAT, 0, 0, rand_small());
    repeat (3) push_sample(rand_small(), rand_small());

    add_random(45);

    // widest limits: only saturation bites
    wait_idle();
    write_limits(Q_MIN, Q_MAX, Q_MIN, Q_MAX);
    add_random(45);

    // crossed limits, and a long receiver stall so the core backs up
    wait_idle();
    write_limits(q_t'(65536), q_t'(-65536), q_t'(131072), q_t'(-131072));
    hold_req = 1'b1;
    repeat (6) push_sample(rand_coef(), rand_coef());
    add_random(40);

    wait_idle();
    write_limits(q_t'(-int'($urandom_range(0, 262144))), q_t'($urandom_range(0, 262144)),
                 q_t'(-int'($urandom_range(0, 4194304))), q_t'($urandom_range(0, 4194304)));
    add_random(45);

    // degenerate: increment pinned to the top, control free to saturate
    wait_idle();
    write_limits(Q_MAX, Q_MAX, Q_MIN, Q_MAX);
    add_random(40);

    wait_idle();
    write_limits(q_t'($urandom), q_t'($urandom), q_t'($urandom), q_t'($urandom));
    add_random(45);

    wait_idle();
    if (err_count == 0 && pending_outputs.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/dmc_pkg.sv
hdl/dmc_coef.sv
hdl/dmc_hist.sv
hdl/dmc_mac.sv
hdl/dmc_control_step_core.sv
tb/tb_top.sv
